### hw/rtl/bfiq_pkg.sv
// Shared types, hash constants and the hash function for the bloom filter.
package bfiq_pkg;

    // Item command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Multiplicative hash constants (a, b) for the three hashes
    localparam logic [31:0] MUL_0 = 32'd31;
    localparam logic [31:0] ADD_0 = 32'd1150616525;
    localparam logic [31:0] MUL_1 = 32'd23;
    localparam logic [31:0] ADD_1 = 32'd572251735;
    localparam logic [31:0] MUL_2 = 32'd47;
    localparam logic [31:0] ADD_2 = 32'd258054038;

    typedef enum logic [1:0] {
        H_SEL_0,
        H_SEL_1,
        H_SEL_2
    } t_hash_sel;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC0,
        S_ACC1,
        S_ACC2,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic      load;      // take the offered item, compute first address
        logic      clr_step;  // clear one word of the store
        logic      access;    // store access at the current bit address
        logic      hash_upd;  // compute the next address from the held key
        t_hash_sel hash_sel;
        logic      check;     // fold the previous read bit into the running AND
        logic      out_load;  // load the query answer into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic out_free;
    } t_dp_sts;

    // Only the low 32 bits of each product/sum reach the address, so the
    // 64-bit wrap of the full hash never matters here.
    function automatic logic [31:0] hash_mix(input logic [63:0] key, input t_hash_sel sel);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x;
        logic [31:0] y;
        unique case (sel)
            H_SEL_0: begin
                a = MUL_0;
                b = ADD_0;
            end
            H_SEL_1: begin
                a = MUL_1;
                b = ADD_1;
            end
            H_SEL_2: begin
                a = MUL_2;
                b = ADD_2;
            end
            default: begin
                a = MUL_0;
                b = ADD_0;
            end
        endcase
        x = key[63:32] * a + b;
        y = key[31:0] * a + b;
        return x ^ y;
    endfunction

endpackage

### hw/rtl/bfiq_ctrl.sv
// Controller state machine: clearing pass, three store accesses per item, result hand-off.
module bfiq_ctrl
    import bfiq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_ACC0;
            end
            S_ACC0: n_state = S_ACC1;
            S_ACC1: n_state = S_ACC2;
            S_ACC2: begin
                if (i_sts.is_query) begin
                    n_state = S_FIN;
                end else begin
                    n_state = i_valid ? S_ACC0 : S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) n_state = i_valid ? S_ACC0 : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_ACC0: begin
                o_cmd.access   = 1'b1;
                o_cmd.hash_upd = 1'b1;
                o_cmd.hash_sel = H_SEL_1;
            end
            S_ACC1: begin
                o_cmd.access   = 1'b1;
                o_cmd.hash_upd = 1'b1;
                o_cmd.hash_sel = H_SEL_2;
                o_cmd.check    = 1'b1;
            end
            S_ACC2: begin
                o_cmd.access = 1'b1;
                o_cmd.check  = 1'b1;
                o_ready      = !i_sts.is_query;
            end
            S_FIN: begin
                o_cmd.out_load = i_sts.out_free;
                o_ready        = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        o_cmd.load = o_ready && i_valid;
    end

endmodule

### hw/rtl/bfiq_dp.sv
// Datapath: hash unit, bit store with per-bit write enable, query AND and output register.
module bfiq_dp
    import bfiq_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic          i_command,
    input  logic [63:0]   i_key,
    output logic          o_valid,
    output logic          o_found,
    input  logic          i_stall
);

    localparam int WordBits = ADDR_BITS - 6;
    localparam int Words    = 1 << WordBits;

    logic [63:0]          r_bits [Words];
    logic [63:0]          r_key;
    logic                 r_cmd;
    logic [ADDR_BITS-1:0] r_addr;
    logic [5:0]           r_pos;
    logic [63:0]          r_rd_word;
    logic                 r_all;
    logic [WordBits-1:0]  r_clr_addr;
    logic                 r_out_valid;
    logic                 r_out_found;

    logic [63:0]          hash_key;
    t_hash_sel            hash_sel;
    logic [31:0]          hash_val;
    logic                 mem_we;
    logic [WordBits-1:0]  mem_addr;
    logic [63:0]          we_mask;
    logic                 we_data;
    logic                 last_bit;

    // Shared hash unit: first address from the incoming key, later ones from the held key
    assign hash_key = i_cmd.load ? i_key : r_key;
    assign hash_sel = i_cmd.load ? H_SEL_0 : i_cmd.hash_sel;
    assign hash_val = hash_mix(hash_key, hash_sel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_cmd <= i_command;
        end
        if (i_cmd.load || i_cmd.hash_upd) begin
            r_addr <= hash_val[ADDR_BITS-1:0];
        end
    end

    // Store port: clearing sweep writes whole words, add sets one bit, query reads
    assign mem_we   = i_cmd.clr_step || (i_cmd.access && (r_cmd == CMD_ADD));
    assign mem_addr = i_cmd.clr_step ? r_clr_addr : r_addr[ADDR_BITS-1:6];
    assign we_mask  = i_cmd.clr_step ? '1 : (64'd1 << r_addr[5:0]);
    assign we_data  = !i_cmd.clr_step;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int b = 0; b < 64; b++) begin
                if (we_mask[b]) r_bits[mem_addr][b] <= we_data;
            end
        end else if (i_cmd.access) begin
            r_rd_word <= r_bits[mem_addr];
        end
    end

    // Clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Running AND over the three looked-up bits
    assign last_bit = r_rd_word[r_pos];

    always_ff @(posedge i_clk) begin
        if (i_cmd.access) r_pos <= r_addr[5:0];
        if (i_cmd.load) begin
            r_all <= 1'b1;
        end else if (i_cmd.check) begin
            r_all <= r_all && last_bit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out_found <= r_all && last_bit;
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out_found;
    assign o_sts.clr_last = (r_clr_addr == {WordBits{1'b1}});
    assign o_sts.is_query = (r_cmd == CMD_QUERY);
    assign o_sts.out_free = !r_out_valid || !i_stall;

endmodule

### hw/rtl/bloom_filter_insert_query.sv
// Bloom filter top level: three-hash add/query over a 64-bit-word bit store.
// A query answer is loaded into the output register in S_FIN, which waits while the output is stalled.
// An add runs S_ACC0 to S_ACC2, a query also S_FIN, as the single store port does one access per hash.
// Reset: synchronous, active low; then a clearing pass over all 2^(ADDR_BITS-6) words (1024 by default)
// zeroes the store, and no item is accepted until it ends.
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [63:0] i_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    ready;

    bfiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (dp_sts),
        .o_ready (ready),
        .o_cmd   (dp_cmd)
    );

    bfiq_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .i_command (i_command),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .o_found   (o_found),
        .i_stall   (i_stall)
    );

    assign o_stall = !ready;

endmodule

### hw/rtl/bfiq_checker.sv
// Port-level checks for the bloom filter top level, with its bind.
module bfiq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_found
);

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The clearing pass holds off items right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_stall)
        else $error("item taken during clearing pass");

    // After an item is accepted, o_stall stays high while the store serves it in S_ACC0 and S_ACC1
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall ##1 o_stall)
        else $error("items accepted too close together");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found)))
        else $error("stalled result changed");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_found (o_found)
);
